/* design/assert_macros.svh */
// Assertion macros shared by the reassembler modules.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define SPR_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SPR_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define SPR_ASSERT(label, clk, rstn, prop, msg)
`define SPR_NEVER(label, clk, rstn, cond, msg)
`endif

`endif

/* design/spr_pkg.sv */
`timescale 1ns / 1ps

package spr_pkg;

    localparam int unsigned BLOCK_BYTES_DEF = 4096;

    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [7:0]  SEQ_FIRST = 8'h00;
    localparam logic [7:0]  SEQ_FINAL = 8'hFF;
    localparam logic [15:0] POS_MAX   = 16'hFFFF;

    // Result queue geometry.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    localparam int unsigned M_TDATA_W = 72;

    typedef enum logic [1:0] {
        ST_ACK       = 2'd0,
        ST_CRC_ERR   = 2'd1,
        ST_INDEX_ERR = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_ANSWER = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t        kind;
        logic [7:0]   byte_value;
        logic [11:0]  byte_offset;
        logic [15:0]  sector_number;
        status_t      status;
        logic [31:0]  bytes_committed;
        logic         last_result;
    } result_t;

    // Results produced by one accepted request; second is used only when count is 2.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    // CRC-16, polynomial 0x1021, MSB first, one byte per call.
    function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* design/sector_packet_reassembler.sv */
`timescale 1ns / 1ps
// Sector packet reassembler.
// The s_axis channel carries one firmware packet byte per request in tdata, the end of the
// packet in tlast, and in tuser a 1 for a begin-transfer request that clears the expected
// sector and the committed byte total. The m_axis channel returns staged payload bytes
// (tuser 0) with their block offset, and a sector answer (tuser 1) with the status and the
// committed total at the end of a final packet for the expected sector or of a packet for
// another sector past its header; tlast marks the last result caused by a request.
// A request is decoded and all block state updated in the cycle it is accepted; its results
// are registered into a four-entry result queue, which drives m_axis.
// One request per cycle is taken while the queue holds at most two results. Every request
// gives at most one result except the closing byte of a final packet, which may give two,
// so the rate is one byte per cycle as long as the receiver takes one result per cycle.
// When the receiver stalls, the queue fills and s_axis_tready drops once more than two
// results wait; nothing is lost.
// After reset all block state is zero, the queue is empty and s_axis_tready is high.

module sector_packet_reassembler #(
    parameter int unsigned BLOCK_BYTES = spr_pkg::BLOCK_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
    input  logic                          s_axis_tuser,  // [0] cmd
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] byte_value, [19:8] byte_offset, [35:20] sector_number, [37:36] status,
    // [69:38] bytes_committed, [71:70] zero
    output logic [spr_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tuser,  // [0] kind
    output logic                          m_axis_tlast
);

    logic             in_accept;
    logic             room;
    spr_pkg::push_t   push;
    spr_pkg::result_t m_result;

    assign s_axis_tready = room;
    assign in_accept     = s_axis_tvalid && room;

    spr_core #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_cmd    (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .push      (push)
    );

    spr_out_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room     (room),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_result (m_result)
    );

    assign m_axis_tdata = {2'b00, m_result.bytes_committed, m_result.status,
                           m_result.sector_number, m_result.byte_offset,
                           m_result.byte_value};
    assign m_axis_tuser = m_result.kind;
    assign m_axis_tlast = m_result.last_result;

endmodule

/* design/spr_core.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spr_core #(
    parameter int unsigned BLOCK_BYTES = spr_pkg::BLOCK_BYTES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_accept,
    input  logic            in_cmd,
    input  logic [7:0]      in_data,
    input  logic            in_last,
    output spr_pkg::push_t  push
);

    localparam logic [15:0] BLOCK_LIMIT = 16'(BLOCK_BYTES);

    logic [15:0] pos_reg,    pos_next;
    logic [15:0] sector_reg, sector_next;
    logic [7:0]  seq_reg,    seq_next;
    logic [15:0] exp_reg,    exp_next;
    logic [15:0] bl_reg,     bl_next;
    logic [15:0] cs_reg,     cs_next;
    logic [7:0]  held0_reg,  held0_next;
    logic [7:0]  held1_reg,  held1_next;
    logic [1:0]  hc_reg,     hc_next;
    logic [31:0] wt_reg,     wt_next;
    logic        ov_reg,     ov_next;

    logic             match;
    logic             stage_en;
    logic [7:0]       stage_b;
    logic             stage_emit;
    logic             ans_en;
    logic             final_chk;
    logic [7:0]       crc_lo;
    spr_pkg::status_t ans_status;
    spr_pkg::result_t res_stage;
    spr_pkg::result_t res_ans;

    always_comb begin
        pos_next    = pos_reg;
        sector_next = sector_reg;
        seq_next    = seq_reg;
        exp_next    = exp_reg;
        bl_next     = bl_reg;
        cs_next     = cs_reg;
        held0_next  = held0_reg;
        held1_next  = held1_reg;
        hc_next     = hc_reg;
        wt_next     = wt_reg;
        ov_next     = ov_reg;
        match       = (sector_reg == exp_reg);
        stage_en    = 1'b0;
        stage_b     = in_data;
        stage_emit  = 1'b0;
        ans_en      = 1'b0;
        final_chk   = 1'b0;
        crc_lo      = held0_reg;
        ans_status  = spr_pkg::ST_INDEX_ERR;

        if (in_cmd) begin
            exp_next = 16'h0000;
            wt_next  = 32'h0000_0000;
        end else begin
            if (pos_reg == 16'd0) begin
                sector_next = {8'h00, in_data};
            end else if (pos_reg == 16'd1) begin
                sector_next = {in_data, sector_reg[7:0]};
            end else if (pos_reg == 16'd2) begin
                seq_next = in_data;
                if (!in_last && match && in_data == spr_pkg::SEQ_FIRST) begin
                    bl_next = 16'h0000;
                    cs_next = 16'h0000;
                    ov_next = 1'b0;
                end
            end else if (!match) begin
                ans_en = in_last;
            end else if (seq_reg != spr_pkg::SEQ_FINAL) begin
                stage_en = 1'b1;
            end else if (in_last) begin
                if (hc_reg != 2'd0) begin
                    final_chk = 1'b1;
                    ans_en    = 1'b1;
                    if (hc_reg >= 2'd2) begin
                        stage_en = 1'b1;
                        stage_b  = held0_reg;
                        crc_lo   = held1_reg;
                    end
                end
            end else begin
                // The final packet is delayed two bytes so that the CRC never gets staged.
                if (hc_reg >= 2'd2) begin
                    stage_en   = 1'b1;
                    stage_b    = held0_reg;
                    held0_next = held1_reg;
                    held1_next = in_data;
                end else begin
                    if (hc_reg[0]) begin
                        held1_next = in_data;
                    end else begin
                        held0_next = in_data;
                    end
                    hc_next = hc_reg + 2'd1;
                end
            end

            if (in_last) begin
                pos_next = 16'd0;
                hc_next  = 2'd0;
            end else if (pos_reg != spr_pkg::POS_MAX) begin
                pos_next = pos_reg + 16'd1;
            end

            if (stage_en) begin
                cs_next = spr_pkg::crc16_fold(cs_reg, stage_b);
                if (bl_reg < BLOCK_LIMIT) begin
                    stage_emit = 1'b1;
                    bl_next    = bl_reg + 16'd1;
                end else begin
                    ov_next = 1'b1;
                end
            end

            // The checks see the block state after the last held byte went in.
            if (final_chk) begin
                if (cs_next != {in_data, crc_lo}) begin
                    ans_status = spr_pkg::ST_CRC_ERR;
                end else if (ov_next) begin
                    ans_status = spr_pkg::ST_OVERFLOW;
                end else begin
                    ans_status = spr_pkg::ST_ACK;
                    wt_next    = wt_reg + {16'h0000, bl_next};
                    exp_next   = exp_reg + 16'd1;
                end
            end
        end

        res_stage.kind            = spr_pkg::KIND_DATA;
        res_stage.byte_value      = stage_b;
        res_stage.byte_offset     = bl_reg[11:0];
        res_stage.sector_number   = 16'h0000;
        res_stage.status          = spr_pkg::ST_ACK;
        res_stage.bytes_committed = 32'h0000_0000;
        res_stage.last_result     = !ans_en;

        res_ans.kind            = spr_pkg::KIND_ANSWER;
        res_ans.byte_value      = 8'h00;
        res_ans.byte_offset     = 12'h000;
        res_ans.sector_number   = sector_reg;
        res_ans.status          = ans_status;
        res_ans.bytes_committed = wt_next;
        res_ans.last_result     = 1'b1;

        push.first  = stage_emit ? res_stage : res_ans;
        push.second = res_ans;
        push.count  = in_accept ? ({1'b0, stage_emit} + {1'b0, ans_en}) : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= 16'h0000;
            sector_reg <= 16'h0000;
            seq_reg    <= 8'h00;
            exp_reg    <= 16'h0000;
            bl_reg     <= 16'h0000;
            cs_reg     <= 16'h0000;
            held0_reg  <= 8'h00;
            held1_reg  <= 8'h00;
            hc_reg     <= 2'd0;
            wt_reg     <= 32'h0000_0000;
            ov_reg     <= 1'b0;
        end else if (in_accept) begin
            pos_reg    <= pos_next;
            sector_reg <= sector_next;
            seq_reg    <= seq_next;
            exp_reg    <= exp_next;
            bl_reg     <= bl_next;
            cs_reg     <= cs_next;
            held0_reg  <= held0_next;
            held1_reg  <= held1_next;
            hc_reg     <= hc_next;
            wt_reg     <= wt_next;
            ov_reg     <= ov_next;
        end
    end

    `SPR_NEVER(a_held_count_range, aclk, aresetn, hc_reg == 2'd3, "held byte count ran past two")
    `SPR_ASSERT(a_two_results_at_end, aclk, aresetn, push.count == 2'd2 |-> in_accept && in_last && !in_cmd, "two results outside the end of a final packet")
    `SPR_ASSERT(a_cmd_clears, aclk, aresetn, in_accept && in_cmd |=> exp_reg == 16'h0000 && wt_reg == 32'h0000_0000, "begin-transfer request did not clear the transfer state")

endmodule

/* design/spr_out_queue.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spr_out_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  spr_pkg::push_t    push,
    output logic              room,
    output logic              m_valid,
    input  logic              m_ready,
    output spr_pkg::result_t  m_result
);

    spr_pkg::result_t entries [spr_pkg::QUEUE_DEPTH];

    logic [spr_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [spr_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [spr_pkg::QCNT_W-1:0] count_reg,  count_next;
    logic                       pop;

    assign pop      = m_valid && m_ready;
    assign m_valid  = (count_reg != '0);
    assign m_result = entries[rd_ptr_reg];
    // Room for the largest burst one request can cause.
    assign room     = (count_reg <= spr_pkg::QCNT_W'(spr_pkg::QUEUE_DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + spr_pkg::QPTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + spr_pkg::QPTR_W'(pop);
        count_next  = count_reg + spr_pkg::QCNT_W'(push.count) - spr_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entries[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entries[wr_ptr_reg + spr_pkg::QPTR_W'(1)] <= push.second;
        end
    end

    `SPR_NEVER(a_count_bound, aclk, aresetn, count_reg > spr_pkg::QCNT_W'(spr_pkg::QUEUE_DEPTH), "result queue count exceeds its depth")
    `SPR_ASSERT(a_push_has_room, aclk, aresetn, push.count != 2'd0 |-> room, "results pushed without room")
    `SPR_ASSERT(a_pop_drains, aclk, aresetn, pop && push.count == 2'd0 |=> count_reg == $past(count_reg) - spr_pkg::QCNT_W'(1), "a taken result did not leave the queue")

endmodule

/* tb/sector_packet_reassembler_tb.sv */
`timescale 1ns / 1ps

module sector_packet_reassembler_tb;

    localparam int unsigned BLOCK_LIMIT = spr_pkg::BLOCK_BYTES_DEF;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          MAX_REPORTS = 100;
    localparam logic        CMD_BYTE    = 1'b0;
    localparam logic        CMD_BEGIN   = 1'b1;

    typedef logic [7:0] byte_q_t[$];

    logic                          aclk;
    logic                          aresetn;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata;
    logic                          s_axis_tuser;
    logic                          s_axis_tlast;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [spr_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic                          m_axis_tuser;
    logic                          m_axis_tlast;

    // Mirror of the reassembler state.
    logic [15:0] cur_pos;
    logic [15:0] cur_sector;
    logic [7:0]  cur_seq;
    logic [15:0] want_sector;
    logic [15:0] blk_len;
    logic [15:0] blk_crc;
    logic [7:0]  crc_hold [2];
    logic [1:0]  crc_hold_cnt;
    logic [31:0] file_total;
    logic        blk_overflow;

    // Staged bytes and sector answers the block still owes, oldest first.
    spr_pkg::result_t owed_results[$];
    byte_q_t          no_bytes;

    int  mismatch_count;
    int  bytes_sent;
    int  cycle_count;
    bit  send_gaps_on;
    bit  recv_stalls_on;
    int  send_run_left;
    int  hold_request;
    int  hold_left;
    int  stall_left;
    int  ready_run_left;

    sector_packet_reassembler #(
        .BLOCK_BYTES(BLOCK_LIMIT)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 aclk = ~aclk;

    // Bitwise CRC-16/XMODEM: each input bit is shifted in against the MSB.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ b[k];
            c = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ spr_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic byte_q_t random_body(input int n);
        byte_q_t q;
        for (int i = 0; i < n; i++) begin
            q.push_back(8'($urandom_range(0, 255)));
        end
        return q;
    endfunction

    task automatic stage_payload(input logic [7:0] b);
        spr_pkg::result_t r;
        blk_crc = crc_step(blk_crc, b);
        if (blk_len < BLOCK_LIMIT) begin
            r = '0;
            r.kind = spr_pkg::KIND_DATA;
            r.byte_value = b;
            r.byte_offset = blk_len[11:0];
            owed_results.push_back(r);
            blk_len = blk_len + 16'd1;
        end else begin
            blk_overflow = 1'b1;
        end
    endtask

    task automatic post_answer(input logic [15:0] sec, input spr_pkg::status_t st);
        spr_pkg::result_t r;
        r = '0;
        r.kind = spr_pkg::KIND_ANSWER;
        r.sector_number = sec;
        r.status = st;
        r.bytes_committed = file_total;
        owed_results.push_back(r);
    endtask

    // Applies one accepted request to the mirrored state and queues what it produces.
    task automatic reassemble_step(input logic cmd, input logic [7:0] d, input logic last);
        logic             match;
        logic [7:0]       crc_lo;
        logic [15:0]      crc_rx;
        spr_pkg::status_t verdict;
        int               first_new;
        spr_pkg::result_t tail;
        first_new = owed_results.size();
        if (cmd == CMD_BEGIN) begin
            want_sector = '0;
            file_total = '0;
        end else begin
            match = (cur_sector == want_sector);
            if (cur_pos == 16'd0) begin
                cur_sector = {8'h00, d};
            end else if (cur_pos == 16'd1) begin
                cur_sector = cur_sector | {d, 8'h00};
            end else if (cur_pos == 16'd2) begin
                cur_seq = d;
                if (!last && match && d == spr_pkg::SEQ_FIRST) begin
                    blk_len = '0;
                    blk_crc = '0;
                    blk_overflow = 1'b0;
                end
            end else if (!match) begin
                if (last) begin
                    post_answer(cur_sector, spr_pkg::ST_INDEX_ERR);
                end
            end else if (cur_seq != spr_pkg::SEQ_FINAL) begin
                stage_payload(d);
            end else if (last) begin
                if (crc_hold_cnt != 2'd0) begin
                    if (crc_hold_cnt >= 2'd2) begin
                        stage_payload(crc_hold[0]);
                        crc_lo = crc_hold[1];
                    end else begin
                        crc_lo = crc_hold[0];
                    end
                    crc_rx = {d, crc_lo};
                    if (blk_crc != crc_rx) begin
                        verdict = spr_pkg::ST_CRC_ERR;
                    end else if (blk_overflow) begin
                        verdict = spr_pkg::ST_OVERFLOW;
                    end else begin
                        verdict = spr_pkg::ST_ACK;
                        file_total = file_total + {16'h0000, blk_len};
                    end
                    post_answer(cur_sector, verdict);
                    if (verdict == spr_pkg::ST_ACK) begin
                        want_sector = want_sector + 16'd1;
                    end
                end
            end else begin
                // The final packet runs two bytes behind so the CRC is never staged.
                if (crc_hold_cnt >= 2'd2) begin
                    stage_payload(crc_hold[0]);
                    crc_hold[0] = crc_hold[1];
                    crc_hold[1] = d;
                end else begin
                    crc_hold[crc_hold_cnt[0]] = d;
                    crc_hold_cnt = crc_hold_cnt + 2'd1;
                end
            end

            if (last) begin
                cur_pos = '0;
                crc_hold_cnt = '0;
            end else if (cur_pos != spr_pkg::POS_MAX) begin
                cur_pos = cur_pos + 16'd1;
            end
        end
        if (owed_results.size() > first_new) begin
            tail = owed_results.pop_back();
            tail.last_result = 1'b1;
            owed_results.push_back(tail);
        end
    endtask

    task automatic send_byte(input logic cmd, input logic [7:0] d, input logic last);
        int gap;
        gap = 0;
        if (send_gaps_on) begin
            if (send_run_left > 0) begin
                send_run_left = send_run_left - 1;
            end else if ($urandom_range(0, 1) == 1) begin
                gap = $urandom_range(1, 8);
            end else begin
                send_run_left = $urandom_range(0, 24);
            end
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tuser <= cmd;
        s_axis_tlast <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        bytes_sent = bytes_sent + 1;
        reassemble_step(cmd, d, last);
    endtask

    // A final packet carries the CRC of the block as it would stand after its payload.
    task automatic send_packet(input logic [15:0] sector, input logic [7:0] seq,
                               input byte_q_t body, input bit is_final, input bit crc_ok);
        byte_q_t     pkt;
        logic [15:0] crc;
        crc = blk_crc;
        pkt.push_back(sector[7:0]);
        pkt.push_back(sector[15:8]);
        pkt.push_back(seq);
        foreach (body[i]) begin
            pkt.push_back(body[i]);
            crc = crc_step(crc, body[i]);
        end
        if (is_final) begin
            if (!crc_ok) begin
                crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
            end
            pkt.push_back(crc[7:0]);
            pkt.push_back(crc[15:8]);
        end
        foreach (pkt[i]) begin
            send_byte(CMD_BYTE, pkt[i], i == pkt.size() - 1);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (owed_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_first_blocks();
        send_byte(CMD_BEGIN, 8'hFF, 1'b1);
        send_packet(16'h0000, spr_pkg::SEQ_FIRST, '{8'h00, 8'hFF, 8'h80}, 1'b0, 1'b1);
        send_packet(16'h0000, 8'h01, '{8'h7F, 8'h01}, 1'b0, 1'b1);
        send_packet(16'h0000, spr_pkg::SEQ_FINAL, '{8'hAA, 8'h55}, 1'b1, 1'b1);
        send_packet(16'h0001, spr_pkg::SEQ_FIRST, random_body(6), 1'b0, 1'b1);
        send_packet(16'h0001, spr_pkg::SEQ_FINAL, no_bytes, 1'b1, 1'b1);
        drain_results();
    endtask

    task automatic test_status_errors();
        send_packet(want_sector, spr_pkg::SEQ_FIRST, random_body(4), 1'b0, 1'b1);
        send_packet(want_sector, spr_pkg::SEQ_FINAL, random_body(3), 1'b1, 1'b0);
        send_packet(16'hFFFF, spr_pkg::SEQ_FIRST, random_body(2), 1'b0, 1'b1);
        send_packet(want_sector ^ 16'h0100, spr_pkg::SEQ_FINAL, random_body(1), 1'b1, 1'b1);
        send_packet(want_sector + 16'd1, 8'h02, random_body(1), 1'b0, 1'b1);
        // The block state survives the answers above, so this one is acknowledged.
        send_packet(want_sector, spr_pkg::SEQ_FINAL, random_body(2), 1'b1, 1'b1);
        drain_results();
    endtask

    task automatic test_short_packets();
        logic [15:0] s;
        s = want_sector;
        send_byte(CMD_BYTE, 8'hFF, 1'b1);
        send_byte(CMD_BYTE, s[7:0], 1'b0);
        send_byte(CMD_BYTE, s[15:8], 1'b1);
        send_packet(s, spr_pkg::SEQ_FIRST, no_bytes, 1'b0, 1'b1);
        send_packet(~s, spr_pkg::SEQ_FIRST, no_bytes, 1'b0, 1'b1);
        send_packet(s, spr_pkg::SEQ_FINAL, '{8'h12}, 1'b0, 1'b1);
        send_packet(~s, spr_pkg::SEQ_FINAL, '{8'h34}, 1'b0, 1'b1);
        send_packet(s, 8'h01, '{8'hC3}, 1'b0, 1'b1);
        send_packet(s, spr_pkg::SEQ_FINAL, no_bytes, 1'b1, 1'b1);
        drain_results();
    endtask

    task automatic test_transfer_restart();
        logic [15:0] s;
        s = want_sector;
        send_byte(CMD_BYTE, s[7:0], 1'b0);
        send_byte(CMD_BYTE, s[15:8], 1'b0);
        // A begin request in mid-packet must not disturb the packet position.
        send_byte(CMD_BEGIN, 8'h00, 1'b0);
        send_byte(CMD_BYTE, spr_pkg::SEQ_FIRST, 1'b0);
        send_byte(CMD_BYTE, 8'h5A, 1'b1);
        send_packet(16'h0000, spr_pkg::SEQ_FIRST, random_body(5), 1'b0, 1'b1);
        send_packet(16'h0000, spr_pkg::SEQ_FINAL, random_body(4), 1'b1, 1'b1);
        drain_results();
    endtask

    task automatic test_receiver_hold();
        hold_request = 300;
        send_packet(want_sector, spr_pkg::SEQ_FIRST, random_body(40), 1'b0, 1'b1);
        send_packet(want_sector, spr_pkg::SEQ_FINAL, random_body(8), 1'b1, 1'b1);
        drain_results();
    endtask

    task automatic test_block_limits();
        bit gaps_were_on;
        gaps_were_on = send_gaps_on;
        send_gaps_on = 1'b0;
        send_packet(want_sector, spr_pkg::SEQ_FIRST, random_body(120), 1'b0, 1'b1);
        send_packet(want_sector, 8'h01, random_body(60), 1'b0, 1'b1);
        send_packet(want_sector, spr_pkg::SEQ_FINAL, random_body(3), 1'b1, 1'b1);
        send_packet(want_sector, spr_pkg::SEQ_FINAL, no_bytes, 1'b1, 1'b0);
        send_gaps_on = gaps_were_on;
        send_packet(want_sector, spr_pkg::SEQ_FIRST, random_body(7), 1'b0, 1'b1);
        send_packet(want_sector, spr_pkg::SEQ_FINAL, random_body(1), 1'b1, 1'b1);
        drain_results();
    endtask

    task automatic test_random_traffic(input int byte_budget);
        int          stop_at;
        int          roll;
        int          n;
        logic [15:0] sec;
        stop_at = bytes_sent + byte_budget;
        while (bytes_sent < stop_at) begin
            roll = $urandom_range(0, 99);
            sec = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 16'hFFFF)) : want_sector;
            if (roll < 4) begin
                send_byte(CMD_BEGIN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else if (roll < 10) begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) begin
                    send_byte(CMD_BYTE, 8'($urandom_range(0, 255)), i == n - 1);
                end
            end else if (roll < 13) begin
                send_packet(sec, spr_pkg::SEQ_FINAL, random_body(1), 1'b0, 1'b1);
            end else if (roll < 20) begin
                send_packet(sec, 8'($urandom_range(0, 255)),
                            random_body($urandom_range(1, 12)), 1'b0, 1'b1);
            end else begin
                if ($urandom_range(0, 9) != 0) begin
                    send_packet(sec, spr_pkg::SEQ_FIRST, random_body($urandom_range(0, 16)),
                                1'b0, 1'b1);
                end
                repeat ($urandom_range(0, 2)) begin
                    send_packet(sec, 8'($urandom_range(1, 254)),
                                random_body($urandom_range(1, 16)), 1'b0, 1'b1);
                end
                send_packet(sec, spr_pkg::SEQ_FINAL, random_body($urandom_range(0, 16)), 1'b1,
                            $urandom_range(0, 6) != 0);
            end
        end
        drain_results();
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            end
        end
    endtask

    always @(posedge aclk) begin : result_check
        spr_pkg::result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (owed_results.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected result, expected none, got tuser %0h tdata %0h",
                             $time, m_axis_tuser, m_axis_tdata);
                end
            end else begin
                want = owed_results.pop_front();
                compare_field("kind", 32'(want.kind), 32'(m_axis_tuser));
                compare_field("byte_value", 32'(want.byte_value), 32'(m_axis_tdata[7:0]));
                compare_field("byte_offset", 32'(want.byte_offset), 32'(m_axis_tdata[19:8]));
                compare_field("sector_number", 32'(want.sector_number),
                              32'(m_axis_tdata[35:20]));
                compare_field("status", 32'(want.status), 32'(m_axis_tdata[37:36]));
                compare_field("bytes_committed", want.bytes_committed, m_axis_tdata[69:38]);
                compare_field("last_result", 32'(want.last_result), 32'(m_axis_tlast));
            end
        end
    end

    // Receiver: random stall bursts, stretches of steady acceptance, and long hold-offs.
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (ready_run_left > 0 || !recv_stalls_on) begin
            if (ready_run_left > 0) begin
                ready_run_left = ready_run_left - 1;
            end
            m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 1) == 1) begin
            stall_left = $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end else begin
            ready_run_left = $urandom_range(0, 24);
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count = cycle_count + 1;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        cur_pos = '0;
        cur_sector = '0;
        cur_seq = '0;
        want_sector = '0;
        blk_len = '0;
        blk_crc = '0;
        crc_hold[0] = '0;
        crc_hold[1] = '0;
        crc_hold_cnt = '0;
        file_total = '0;
        blk_overflow = 1'b0;
        no_bytes = {};
        mismatch_count = 0;
        bytes_sent = 0;
        send_run_left = 0;
        hold_request = 0;
        hold_left = 0;
        stall_left = 0;
        ready_run_left = 0;
        send_gaps_on = 1'b1;
        recv_stalls_on = 1'b1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_first_blocks();
        test_status_errors();
        test_short_packets();
        test_transfer_restart();
        test_receiver_hold();
        test_block_limits();
        test_random_traffic(1300);
        send_gaps_on = 1'b0;
        recv_stalls_on = 1'b0;
        test_random_traffic(300);

        repeat (16) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
